>>> sv/bcce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcce_pkg;

   // Request field widths
   localparam int FUNC_W   = 2;
   localparam int PX_W     = 14;
   localparam int PY_W     = 13;
   localparam int RADIUS_W = 12;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 10;

   // Pixel coordinate width for the largest supported map (4096 x 4096)
   localparam int CRD_W    = 12;
   localparam int R2_W     = 2 * RADIUS_W;

   localparam int QUEUE_DEPTH = 2;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_CARVE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FILL  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

   // Work kinds handed from the front to the back
   typedef enum logic [1:0] {
      OP_REPLY = 2'd0,
      OP_FILL  = 2'd1,
      OP_CARVE = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef struct packed {
      op_type                op;
      logic                  solid;
      logic                  rejected;
      logic [CRD_W-1:0]      x0;
      logic [CRD_W-1:0]      x1;
      logic [CRD_W-1:0]      y0;
      logic [CRD_W-1:0]      y1;
      logic [PX_W-1:0]       px;
      logic [PY_W-1:0]       py;
      logic [RADIUS_W-1:0]   radius;
   } cmd_type;

endpackage

`default_nettype wire

>>> sv/bcce_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bcce_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/bcce_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bcce_front
   import bcce_pkg::*;
#(
   parameter int MAP_WIDTH  = 1024,
   parameter int MAP_HEIGHT = 512,
   parameter int FRAC_BITS  = 4
) (
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [PX_W-1:0]     req_pos_x,
   input  wire logic [PY_W-1:0]     req_pos_y,
   input  wire logic [RADIUS_W-1:0] req_radius,
   input  wire logic [WIDTH_W-1:0]  req_rect_width,
   input  wire logic [HEIGHT_W-1:0] req_rect_height,
   input  wire logic                clearing,
   output      logic                cmd_valid,
   input  wire logic                cmd_ready,
   output      cmd_type             cmd
);

   // Wide enough for position plus scaled rectangle size plus rounding
   localparam int FW = ((WIDTH_W + FRAC_BITS > PX_W) ? WIDTH_W + FRAC_BITS : PX_W) + 2;

   localparam logic [FW-1:0] X_LAST  = FW'(MAP_WIDTH - 1);
   localparam logic [FW-1:0] Y_LAST  = FW'(MAP_HEIGHT - 1);
   localparam logic [FW-1:0] X_LIMIT = FW'(MAP_WIDTH);
   localparam logic [FW-1:0] Y_LIMIT = FW'(MAP_HEIGHT);
   localparam logic [FW-1:0] X_EDGE  = FW'(MAP_WIDTH << FRAC_BITS);
   localparam logic [FW-1:0] Y_EDGE  = FW'(MAP_HEIGHT << FRAC_BITS);
   localparam logic [FW-1:0] ROUND   = FW'((1 << FRAC_BITS) - 1);

   typedef struct packed {
      logic [FW-1:0] lo;
      logic [FW-1:0] hi;
      logic          empty;
   } span_type;

   // Bounding span of a carve along one axis, clipped to the carvable area
   function automatic span_type carve_span(input logic [FW-1:0] p,
                                           input logic [FW-1:0] r,
                                           input logic [FW-1:0] lim);
      span_type s;
      s.lo = (p > r) ? ((p - r) >> FRAC_BITS) : '0;
      if (s.lo < FW'(2)) s.lo = FW'(2);
      s.hi = (p + r) >> FRAC_BITS;
      if (s.hi > lim) s.hi = lim;
      s.empty = (s.lo > s.hi);
      return s;
   endfunction

   // Span of a fill along one axis; lim is the map size on that axis
   function automatic span_type fill_span(input logic [FW-1:0] p,
                                          input logic [FW-1:0] n,
                                          input logic [FW-1:0] lim);
      span_type      s;
      logic [FW-1:0] stop;
      stop = (p + (n << FRAC_BITS) + ROUND) >> FRAC_BITS;
      if (stop > lim) stop = lim;
      s.lo    = p >> FRAC_BITS;
      s.hi    = stop - FW'(1);
      s.empty = (s.lo >= stop);
      return s;
   endfunction

   logic [FW-1:0] px_w;
   logic [FW-1:0] py_w;
   logic [FW-1:0] qx;
   logic [FW-1:0] qy;
   span_type      cx;
   span_type      cy;
   span_type      fx;
   span_type      fy;
   logic          reject;

   assign px_w = FW'(req_pos_x);
   assign py_w = FW'(req_pos_y);
   assign qx   = px_w >> FRAC_BITS;
   assign qy   = py_w >> FRAC_BITS;
   assign cx   = carve_span(px_w, FW'(req_radius), X_LAST);
   assign cy   = carve_span(py_w, FW'(req_radius), Y_LAST);
   assign fx   = fill_span(px_w, FW'(req_rect_width), X_LIMIT);
   assign fy   = fill_span(py_w, FW'(req_rect_height), Y_LIMIT);

   assign reject = (req_pos_x == '0) || (req_pos_y == '0) ||
                   (px_w > X_EDGE) || (py_w > Y_EDGE);

   assign cmd_valid = req_valid && !clearing;
   assign req_ready = cmd_ready && !clearing;

   always_comb begin
      cmd          = '0;
      cmd.op       = OP_REPLY;
      cmd.px       = req_pos_x;
      cmd.py       = req_pos_y;
      cmd.radius   = req_radius;
      unique case (req_func)
         FUNC_CARVE: begin
            if (reject) begin
               cmd.rejected = 1'b1;
            end else if (!cx.empty && !cy.empty) begin
               cmd.op = OP_CARVE;
               cmd.x0 = CRD_W'(cx.lo);
               cmd.x1 = CRD_W'(cx.hi);
               cmd.y0 = CRD_W'(cy.lo);
               cmd.y1 = CRD_W'(cy.hi);
            end
         end
         FUNC_FILL: begin
            if (!fx.empty && !fy.empty) begin
               cmd.op = OP_FILL;
               cmd.x0 = CRD_W'(fx.lo);
               cmd.x1 = CRD_W'(fx.hi);
               cmd.y0 = CRD_W'(fy.lo);
               cmd.y1 = CRD_W'(fy.hi);
            end
         end
         FUNC_QUERY: begin
            // Border and off-map pixels read solid without a memory access
            if ((qx <= FW'(1)) || (qy <= FW'(1)) || (qx >= X_LIMIT) || (qy >= Y_LIMIT)) begin
               cmd.solid = 1'b1;
            end else begin
               cmd.op = OP_QUERY;
               cmd.x0 = CRD_W'(qx);
               cmd.y0 = CRD_W'(qy);
            end
         end
         default: begin
            cmd.op = OP_REPLY;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> sv/bcce_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bcce_queue
   import bcce_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output      logic    in_ready,
   input  wire cmd_type in_cmd,
   output      logic    out_valid,
   input  wire logic    out_ready,
   output      cmd_type out_cmd
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

>>> sv/bcce_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bcce_back
   import bcce_pkg::*;
#(
   parameter int MAP_WIDTH  = 1024,
   parameter int MAP_HEIGHT = 512,
   parameter int FRAC_BITS  = 4
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    cmd_valid,
   output      logic                                    cmd_ready,
   input  wire cmd_type                                 cmd,
   output      logic                                    clearing,
   output      logic                                    ram_we,
   output      logic [$clog2(MAP_WIDTH*MAP_HEIGHT)-1:0] ram_waddr,
   output      logic                                    ram_wdata,
   output      logic                                    ram_re,
   output      logic [$clog2(MAP_WIDTH*MAP_HEIGHT)-1:0] ram_raddr,
   input  wire logic                                    ram_rdata,
   output      logic                                    rsp_valid,
   input  wire logic                                    rsp_ready,
   output      logic                                    rsp_solid,
   output      logic                                    rsp_rejected
);

   localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(MAP_WIDTH);
   localparam int YW    = $clog2(MAP_HEIGHT);
   localparam int CW0   = (XW > YW) ? XW + FRAC_BITS : YW + FRAC_BITS;
   localparam int CW    = (CW0 > PX_W) ? CW0 : PX_W;
   localparam int DW    = CW + 1;
   localparam int QW    = 2 * DW;
   localparam int STEP  = 1 << FRAC_BITS;

   localparam logic signed [QW-1:0] STEP_SQ = QW'(STEP * STEP);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_SETUP  = 8'b0000_0100,
      ST_SQUARE = 8'b0000_1000,
      ST_SCAN   = 8'b0001_0000,
      ST_READ   = 8'b0010_0000,
      ST_WAIT   = 8'b0100_0000,
      ST_REPLY  = 8'b1000_0000
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [XW-1:0]           x_ff, x_in;
   logic [YW-1:0]           y_ff, y_in;
   logic signed [DW-1:0]    dx_ff, dx_in;
   logic signed [DW-1:0]    dy_ff, dy_in;
   logic signed [DW-1:0]    dx0_ff, dx0_in;
   logic signed [QW-1:0]    dx2_ff, dx2_in;
   logic signed [QW-1:0]    dy2_ff, dy2_in;
   logic signed [QW-1:0]    dx20_ff, dx20_in;
   logic [AW-1:0]           base_ff, base_in;
   logic [R2_W-1:0]         r2_ff, r2_in;
   logic                    res_solid_ff, res_solid_in;
   logic                    res_rejected_ff, res_rejected_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_solid_ff, rsp_solid_in;
   logic                    rsp_rejected_ff, rsp_rejected_in;

   logic [XW-1:0]           x0;
   logic [XW-1:0]           x1;
   logic [YW-1:0]           y0;
   logic [YW-1:0]           y1;
   logic [AW-1:0]           pix_addr;
   logic                    in_circle;
   logic                    is_fill;

   assign x0        = cmd_ff.x0[XW-1:0];
   assign x1        = cmd_ff.x1[XW-1:0];
   assign y0        = cmd_ff.y0[YW-1:0];
   assign y1        = cmd_ff.y1[YW-1:0];
   assign pix_addr  = base_ff + AW'(x_ff);
   assign in_circle = (dx2_ff + dy2_ff) < $signed(QW'(r2_ff));
   assign is_fill   = (cmd_ff.op == OP_FILL);

   assign clearing     = (state_ff == ST_CLEAR);
   assign cmd_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_solid    = rsp_solid_ff;
   assign rsp_rejected = rsp_rejected_ff;

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      clr_in          = clr_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      dx_in           = dx_ff;
      dy_in           = dy_ff;
      dx0_in          = dx0_ff;
      dx2_in          = dx2_ff;
      dy2_in          = dy2_ff;
      dx20_in         = dx20_ff;
      base_in         = base_ff;
      r2_in           = r2_ff;
      res_solid_in    = res_solid_ff;
      res_rejected_in = res_rejected_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_solid_in    = rsp_solid_ff;
      rsp_rejected_in = rsp_rejected_ff;
      ram_we          = 1'b0;
      ram_waddr       = pix_addr;
      ram_wdata       = 1'b0;
      ram_re          = 1'b0;
      ram_raddr       = pix_addr;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in          = cmd;
               res_solid_in    = cmd.solid;
               res_rejected_in = cmd.rejected;
               state_in        = (cmd.op == OP_REPLY) ? ST_REPLY : ST_SETUP;
            end
         end
         ST_SETUP: begin
            x_in    = x0;
            y_in    = y0;
            dx0_in  = $signed(DW'(x0) << FRAC_BITS) - $signed(DW'(cmd_ff.px));
            dx_in   = $signed(DW'(x0) << FRAC_BITS) - $signed(DW'(cmd_ff.px));
            dy_in   = $signed(DW'(y0) << FRAC_BITS) - $signed(DW'(cmd_ff.py));
            base_in = AW'(y0) * AW'(MAP_WIDTH);
            r2_in   = R2_W'(cmd_ff.radius) * R2_W'(cmd_ff.radius);
            state_in = (cmd_ff.op == OP_QUERY) ? ST_READ : ST_SQUARE;
         end
         ST_SQUARE: begin
            dx2_in   = QW'(dx_ff) * QW'(dx_ff);
            dx20_in  = QW'(dx_ff) * QW'(dx_ff);
            dy2_in   = QW'(dy_ff) * QW'(dy_ff);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Squares advance by (d + s)^2 = d^2 + 2sd + s^2
            ram_we    = is_fill || in_circle;
            ram_wdata = is_fill;
            if (x_ff == x1) begin
               x_in   = x0;
               dx_in  = dx0_ff;
               dx2_in = dx20_ff;
               if (y_ff == y1) begin
                  res_solid_in    = 1'b0;
                  res_rejected_in = 1'b0;
                  state_in        = ST_REPLY;
               end else begin
                  y_in    = y_ff + YW'(1);
                  dy_in   = dy_ff + DW'(STEP);
                  dy2_in  = dy2_ff + (QW'(dy_ff) <<< (FRAC_BITS + 1)) + STEP_SQ;
                  base_in = base_ff + AW'(MAP_WIDTH);
               end
            end else begin
               x_in   = x_ff + XW'(1);
               dx_in  = dx_ff + DW'(STEP);
               dx2_in = dx2_ff + (QW'(dx_ff) <<< (FRAC_BITS + 1)) + STEP_SQ;
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            res_solid_in    = ram_rdata;
            res_rejected_in = 1'b0;
            state_in        = ST_REPLY;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_solid_in    = res_solid_ff;
               rsp_rejected_in = res_rejected_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      dx_ff           <= dx_in;
      dy_ff           <= dy_in;
      dx0_ff          <= dx0_in;
      dx2_ff          <= dx2_in;
      dy2_ff          <= dy2_in;
      dx20_ff         <= dx20_in;
      base_ff         <= base_in;
      r2_ff           <= r2_in;
      res_solid_ff    <= res_solid_in;
      res_rejected_ff <= res_rejected_in;
      rsp_solid_ff    <= rsp_solid_in;
      rsp_rejected_ff <= rsp_rejected_in;
   end

`ifndef ASSERT_OFF
   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !(cmd_valid && cmd_ready))
      else $error("command taken during clearing pass");

   a_scan_x_in_box: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (x_ff >= x0) && (x_ff <= x1))
      else $error("scan column outside bounding box");

   a_scan_y_in_box: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (y_ff >= y0) && (y_ff <= y1))
      else $error("scan row outside bounding box");

   a_reply_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_REPLY))
      else $error("reply overwrote a pending response");

   a_read_only_in_read: assert property (@(posedge clock) disable iff (reset)
      ram_re |-> (state_ff == ST_READ) && (cmd_ff.op == OP_QUERY))
      else $error("map read outside a query");
`endif

endmodule

`default_nettype wire

>>> sv/bitmap_circle_carve_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Rejected carves, empty spans, border queries and unused codes are answered without a
// map access; a map query reads the map once; a carve or fill sweeps every pixel of
// its box.
// Throughput: one pixel per cycle, set by the single write port of the map memory.
// Reset: after reset a clearing pass writes every map address to empty the map;
// req_ready stays low until it ends.

module bitmap_circle_carve_engine
   import bcce_pkg::*;
#(
   parameter int MAP_WIDTH  = 1024,
   parameter int MAP_HEIGHT = 512,
   parameter int FRAC_BITS  = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [PX_W-1:0]     req_pos_x,
   input  wire logic [PY_W-1:0]     req_pos_y,
   input  wire logic [RADIUS_W-1:0] req_radius,
   input  wire logic [WIDTH_W-1:0]  req_rect_width,
   input  wire logic [HEIGHT_W-1:0] req_rect_height,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic                rsp_solid,
   output      logic                rsp_rejected
);

   localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   // Front to queue
   logic          fq_valid;
   logic          fq_ready;
   cmd_type       fq_cmd;

   // Queue to back
   logic          qb_valid;
   logic          qb_ready;
   cmd_type       qb_cmd;

   logic          clearing;

   // Map memory, one bit per pixel, row-major
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic          ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic          ram_rdata;

   // Classify each request: reject checks, clipped box, trivial answers
   bcce_front #(
      .MAP_WIDTH  (MAP_WIDTH),
      .MAP_HEIGHT (MAP_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_radius      (req_radius),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .clearing        (clearing),
      .cmd_valid       (fq_valid),
      .cmd_ready       (fq_ready),
      .cmd             (fq_cmd)
   );

   // Hold up to QUEUE_DEPTH classified commands so the front can keep taking transfers while the back scans
   bcce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_cmd    (fq_cmd),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_cmd   (qb_cmd)
   );

   // Sweep the box one pixel per cycle, read the map for queries, drive responses
   bcce_back #(
      .MAP_WIDTH  (MAP_WIDTH),
      .MAP_HEIGHT (MAP_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (qb_valid),
      .cmd_ready    (qb_ready),
      .cmd          (qb_cmd),
      .clearing     (clearing),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_re       (ram_re),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_solid    (rsp_solid),
      .rsp_rejected (rsp_rejected)
   );

   bcce_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

`default_nettype wire
